[rtl/wgm_pkg.sv]
// Shared types and constants for the wildcard glob matcher.
`default_nettype none

package wgm_pkg;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_PATH   = 2'd1;
    localparam logic [1:0] REQ_END    = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [7:0] STAR_CH = 8'h2A;
    localparam logic [7:0] ANY_CH  = 8'h3F;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] ch;
    } t_in_item;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic append;
        logic restart;
        logic step;
        logic close;
        logic capture;
    } t_dp_cmd;

endpackage

`default_nettype wire

[rtl/wgm_datapath.sv]
// Pattern store, active position set, star closure and verdict register.
`default_nettype none

module wgm_datapath #(
    parameter int MAX_PATTERN = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wgm_pkg::t_dp_cmd  i_cmd,
    input  logic [7:0]        i_ch,
    output wgm_pkg::t_out_item o_result
);
    import wgm_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LV = $clog2(MAX_PATTERN + 1);

    logic [7:0]         r_pat [MAX_PATTERN];
    logic [LW-1:0]      r_len;
    logic               r_ovf;
    logic [MAX_PATTERN:0] r_act;
    t_out_item          r_result;

    logic [MAX_PATTERN:0] prop;
    logic [MAX_PATTERN:0] stepped;
    logic [MAX_PATTERN:0] closed;
    logic [MAX_PATTERN:0] pr_w;
    logic               room;

    assign room = (r_len < LW'(MAX_PATTERN));

    always_comb begin
        logic live;
        logic is_star;
        prop    = '0;
        stepped = '0;
        for (int p = 0; p < MAX_PATTERN; p++) begin
            live    = (LW'(p) < r_len);
            is_star = (r_pat[p] == STAR_CH);
            prop[p+1] = live & is_star;
            if (r_act[p] && live) begin
                if (is_star) begin
                    stepped[p] = 1'b1;
                end else if ((r_pat[p] == ANY_CH) || (r_pat[p] == i_ch)) begin
                    stepped[p+1] = 1'b1;
                end
            end
        end
    end

    // Parallel prefix: a '*' at p passes activity from position p to p+1.
    always_comb begin
        closed = r_act;
        pr_w   = prop;
        for (int k = 0; k < LV; k++) begin
            closed = closed | (pr_w & (closed << (1 << k)));
            pr_w   = pr_w & (pr_w << (1 << k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && room) begin
            r_pat[r_len[AW-1:0]] <= i_ch;
        end
        if (i_cmd.capture) begin
            r_result.matched          <= r_act[r_len];
            r_result.pattern_overflow <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
            r_act <= (MAX_PATTERN + 1)'(1);
        end else begin
            if (i_cmd.clear) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end else if (i_cmd.append) begin
                if (room) begin
                    r_len <= r_len + LW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.restart) begin
                r_act <= (MAX_PATTERN + 1)'(1);
            end else if (i_cmd.step) begin
                r_act <= stepped;
            end else if (i_cmd.close) begin
                r_act <= closed;
            end
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

[rtl/wgm_ctrl.sv]
// Control state machine: input handshake, command sequencing and result valid.
`default_nettype none

module wgm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_req_type,
    input  logic             i_out_stall,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output wgm_pkg::t_dp_cmd o_cmd
);
    import wgm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_CLOSE = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE) ||
                        (r_out_valid && i_out_stall && (i_req_type == REQ_END));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CLOSE;
                    case (i_req_type)
                        REQ_APPEND: begin
                            o_cmd.append  = 1'b1;
                            o_cmd.restart = 1'b1;
                        end
                        REQ_PATH: begin
                            o_cmd.step = 1'b1;
                        end
                        REQ_END: begin
                            o_cmd.capture = 1'b1;
                            o_cmd.restart = 1'b1;
                        end
                        default: begin
                            o_cmd.clear   = 1'b1;
                            o_cmd.restart = 1'b1;
                        end
                    endcase
                end
            end
            S_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && i_out_stall) || o_cmd.capture;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/wildcard_glob_matcher_unit.sv]
// Top level of the wildcard glob matcher: controller plus datapath.
// For each transfer on the input, the item is applied in the cycle it is
// accepted, and the star closure of the active position set is computed in the next
// cycle by a parallel-prefix network over all MAX_PATTERN+1 positions. An end-of-path
// item returns its verdict from an output register, so the next item can be accepted
// while the verdict still waits to be taken; a second end-of-path item is held off until
// the first is gone. Pattern bytes beyond MAX_PATTERN are dropped and flagged in the
// verdict until the next clear. There is no clearing pass after reset.
`default_nettype none

module wildcard_glob_matcher_unit #(
    parameter int MAX_PATTERN = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wgm_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wgm_pkg::t_out_item o_out_data
);
    import wgm_pkg::*;

    t_dp_cmd cmd;

    wgm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in_data.req_type),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    wgm_datapath #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_ch     (i_in_data.ch),
        .o_result (o_out_data)
    );

endmodule

`default_nettype wire

[rtl/wgm_checker.sv]
// Port-level assertions for the wildcard glob matcher and their bind.
`default_nettype none

module wgm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input wgm_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input wgm_pkg::t_out_item o_out_data
);
    import wgm_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.req_type == REQ_END) |=> o_out_valid)
        else $error("end of path transfer gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.req_type != REQ_END) && !o_out_valid |=> !o_out_valid)
        else $error("result appeared without an end of path transfer");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input accepted during closure cycle");

endmodule

bind wildcard_glob_matcher_unit wgm_checker u_wgm_checker (.*);

`default_nettype wire
